>>> design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the line editor modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define TLE_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// Condition in one cycle that requires another in the following cycle.
`define TLE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/tle_pkg.sv
// ----------------------------------------------------------------------------
// Line editor package
// Types, character codes and sizes shared by the terminal line editor.
// ----------------------------------------------------------------------------
package tle_pkg;

	localparam int LINE_CAPACITY = 256;
	localparam int ADDR_W        = $clog2(LINE_CAPACITY);
	localparam int ERS_W         = 4;

	typedef logic [ADDR_W-1:0] addr_t;

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_ETX    = 8'h03;
	localparam logic [7:0] CH_BEL    = 8'h07;
	localparam logic [7:0] CH_BS     = 8'h08;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_DLE    = 8'h10;
	localparam logic [7:0] CH_DC1    = 8'h11;
	localparam logic [7:0] CH_NAK    = 8'h15;
	localparam logic [7:0] CH_ESC    = 8'h1B;
	localparam logic [7:0] CH_SP     = 8'h20;
	localparam logic [7:0] CH_UP     = 8'h41;
	localparam logic [7:0] CH_DOWN   = 8'h42;
	localparam logic [7:0] CH_RIGHT  = 8'h43;
	localparam logic [7:0] CH_LEFT   = 8'h44;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_DEL    = 8'h7F;

	// Erase bytes in one erase group and in the control-byte prefix.
	localparam logic [ERS_W-1:0] ERS_GROUP = ERS_W'(3);
	localparam logic [ERS_W-1:0] ERS_CTRL  = ERS_W'(6);

	typedef enum logic [1:0] {
		KIND_ECHO  = 2'd0,
		KIND_DONE  = 2'd1,
		KIND_ABORT = 2'd2,
		KIND_READ  = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ESC_IDLE    = 2'd0,
		ESC_SEEN    = 2'd1,
		ESC_BRACKET = 2'd2
	} esc_t;

	typedef enum logic [2:0] {
		TAIL_NONE,
		TAIL_ABORT,
		TAIL_LINE,
		TAIL_BELL,
		TAIL_READ
	} tail_t;

	// Result plan of one item: erase bytes first, then the tail results.
	typedef struct packed {
		logic [ERS_W-1:0] ers;
		tail_t            tail;
		logic [7:0]       len;
		logic             rd_ok;
	} plan_t;

	typedef struct packed {
		logic       we;
		addr_t      addr;
		logic [7:0] data;
	} ram_wr_t;

	typedef struct packed {
		logic  re;
		addr_t addr;
	} ram_rd_t;

endpackage

>>> design/tle_if.sv
// ----------------------------------------------------------------------------
// Line editor channels
// Valid/ready channels for key items and for result items.
// ----------------------------------------------------------------------------
interface tle_in_if;
	logic       valid;
	logic       ready;
	logic       opcode;
	logic [7:0] key_byte;
	logic [7:0] read_index;

	modport source (output valid, opcode, key_byte, read_index, input ready);
	modport sink (input valid, opcode, key_byte, read_index, output ready);
endinterface

interface tle_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [7:0] value;
	logic       last;

	modport source (output valid, kind, value, last, input ready);
	modport sink (input valid, kind, value, last, output ready);
endinterface

>>> design/tle_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tle_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> design/tle_editor.sv
// ----------------------------------------------------------------------------
// Line editor state and key decoder
// Holds the fill count and escape phase and turns one item into a result plan.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tle_editor import tle_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       commit,
	input  logic       op,
	input  logic [7:0] key,
	input  logic [7:0] idx,
	output plan_t      plan,
	output ram_wr_t    wr,
	output ram_rd_t    rd
);

	addr_t      cnt_q, cnt_d;
	esc_t       phase_q, phase_d;
	logic [7:0] c2;
	logic       stop;
	logic       we_raw, re_raw;

	always_comb begin
		plan    = '{ers: '0, tail: TAIL_NONE, len: '0, rd_ok: 1'b0};
		cnt_d   = cnt_q;
		phase_d = phase_q;
		c2      = key;
		stop    = 1'b0;
		we_raw  = 1'b0;
		re_raw  = 1'b0;
		wr.addr = cnt_q;
		wr.data = key;
		rd.addr = ADDR_W'(idx);

		if (op) begin
			plan.tail  = TAIL_READ;
			plan.rd_ok = (32'(idx) < 32'(LINE_CAPACITY));
			re_raw     = 1'b1;
		end else begin
			// Bytes below space and with the top bit set echo two erase groups.
			if (key < CH_SP || key[7]) begin
				plan.ers = ERS_CTRL;
			end

			unique case (phase_q)
				ESC_SEEN: begin
					if (key == CH_LBRACK) begin
						plan.ers = plan.ers + ERS_GROUP;
						phase_d  = ESC_BRACKET;
						stop     = 1'b1;
					end
				end
				ESC_BRACKET: begin
					plan.ers = plan.ers + ERS_GROUP;
					phase_d  = ESC_IDLE;
					if (key == CH_UP || key == CH_DOWN || key == CH_RIGHT) begin
						c2 = CH_DLE;
					end else if (key == CH_LEFT) begin
						c2 = CH_DC1;
					end
				end
				ESC_IDLE: begin
				end
				default: begin
					phase_d = ESC_IDLE;
				end
			endcase

			if (!stop) begin
				unique case (c2) inside
					CH_ESC: begin
						phase_d = ESC_SEEN;
					end
					CH_NUL, CH_NAK, CH_DLE, CH_DC1: begin
					end
					CH_ETX: begin
						we_raw    = 1'b1;
						wr.addr   = '0;
						wr.data   = '0;
						plan.tail = TAIL_ABORT;
						cnt_d     = '0;
						phase_d   = ESC_IDLE;
					end
					CH_CR, CH_LF: begin
						we_raw    = 1'b1;
						wr.data   = '0;
						plan.tail = TAIL_LINE;
						plan.len  = 8'(cnt_q);
						cnt_d     = '0;
						phase_d   = ESC_IDLE;
					end
					CH_BS, CH_DEL: begin
						if (cnt_q != '0) begin
							cnt_d = cnt_q - 1'b1;
						end
						plan.ers = plan.ers + ERS_GROUP;
					end
					default: begin
						if (cnt_q < ADDR_W'(LINE_CAPACITY - 2)) begin
							we_raw = 1'b1;
							cnt_d  = cnt_q + 1'b1;
						end else begin
							plan.tail = TAIL_BELL;
						end
					end
				endcase
			end
		end

		wr.we = we_raw & commit;
		rd.re = re_raw & commit;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			phase_q <= ESC_IDLE;
		end else if (commit) begin
			cnt_q   <= cnt_d;
			phase_q <= phase_d;
		end
	end

	`TLE_ASSERT(a_cnt_range, cnt_q <= ADDR_W'(LINE_CAPACITY - 2), "fill count beyond store limit")
	`TLE_ASSERT_NEXT(a_line_clears, commit && (plan.tail == TAIL_LINE || plan.tail == TAIL_ABORT),
		cnt_q == '0 && phase_q == ESC_IDLE, "line end did not clear editor state")

endmodule

>>> design/tle_seq.sv
// ----------------------------------------------------------------------------
// Result sequencer
// Plays out one item's result plan, one transfer per cycle when not stalled.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tle_seq import tle_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       load,
	input  plan_t      plan,
	input  logic [7:0] rdata,
	output logic       free,
	tle_out_if.source  res
);

	logic [ERS_W-1:0] ers_q;
	logic [1:0]       grp_q;
	logic [1:0]       tpos_q;
	tail_t            tail_q;
	logic [7:0]       len_q;
	logic             rd_ok_q;
	logic             busy, is_final, xfer;

	assign busy     = (ers_q != '0) || (tail_q != TAIL_NONE);
	assign is_final = (ers_q == ERS_W'(1) && tail_q == TAIL_NONE) ||
	                  (ers_q == '0 && (tail_q != TAIL_LINE || tpos_q == 2'd2));
	assign xfer     = res.valid && res.ready;
	assign free     = !busy || (xfer && is_final);

	always_comb begin
		res.valid = busy;
		res.last  = is_final;
		res.kind  = KIND_ECHO;
		res.value = CH_BS;
		if (ers_q != '0) begin
			res.value = (grp_q == 2'd1) ? CH_SP : CH_BS;
		end else begin
			case (tail_q)
				TAIL_ABORT: begin
					res.kind  = KIND_ABORT;
					res.value = '0;
				end
				TAIL_BELL: begin
					res.value = CH_BEL;
				end
				TAIL_READ: begin
					res.kind  = KIND_READ;
					res.value = rd_ok_q ? rdata : '0;
				end
				TAIL_LINE: begin
					if (tpos_q == 2'd0) begin
						res.value = CH_CR;
					end else if (tpos_q == 2'd1) begin
						res.value = CH_LF;
					end else begin
						res.kind  = KIND_DONE;
						res.value = len_q;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ers_q  <= '0;
			grp_q  <= '0;
			tpos_q <= '0;
			tail_q <= TAIL_NONE;
		end else if (load) begin
			ers_q  <= plan.ers;
			grp_q  <= '0;
			tpos_q <= '0;
			tail_q <= plan.tail;
		end else if (xfer) begin
			if (ers_q != '0) begin
				ers_q <= ers_q - 1'b1;
				grp_q <= (grp_q == 2'd2) ? 2'd0 : grp_q + 1'b1;
			end else if (tail_q == TAIL_LINE && tpos_q != 2'd2) begin
				tpos_q <= tpos_q + 1'b1;
			end else begin
				tail_q <= TAIL_NONE;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			len_q   <= plan.len;
			rd_ok_q <= plan.rd_ok;
		end
	end

	`TLE_ASSERT_NEXT(a_idle_after_last, xfer && is_final && !load, !busy,
		"sequencer still busy after final transfer")
	`TLE_ASSERT(a_grp_range, grp_q != 2'd3 && tpos_q != 2'd3, "erase or tail position out of range")

endmodule

>>> design/terminal_line_editor_core.sv
// ----------------------------------------------------------------------------
// Terminal line editor core
// Raw key bytes in; echo bytes, line events and stored line bytes out.
// ----------------------------------------------------------------------------
// Usage. Items arrive on the keys channel: with opcode low the key_byte is a
// raw terminal byte, with opcode high read_index selects a stored line byte.
// Each item produces between zero and twelve result transfers on the results
// channel (echo bytes, a line-done or abort event, or read data), and the
// last of them carries last high. An item that produces nothing vanishes.
// An accepted item waits in the input register until the result sequencer is
// free; the sequencer then loads its plan and offers its first result, and
// further results of the same item follow one per cycle while the receiver
// is ready. Throughput is one item per cycle for items with a single result
// while the receiver is ready, as the sequencer emits one transfer per cycle.
// The next item is taken into the input register while the present one is
// still emitting, and its state update and store write happen the moment
// the sequencer takes it over.
// Reset clears the fill count, the escape phase and both pipeline stages;
// the line store itself is not cleared, and reading an entry never written
// yields an undefined byte. When the receiver stalls, the current result is
// held and the input register fills, after which keys.ready drops.
// ----------------------------------------------------------------------------
module terminal_line_editor_core import tle_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	tle_in_if.sink    keys,
	tle_out_if.source results
);

	logic       vld_s1;
	logic       op_s1;
	logic [7:0] key_s1;
	logic [7:0] idx_s1;
	logic       free;
	logic       commit;
	plan_t      plan;
	ram_wr_t    wr;
	ram_rd_t    rd;
	logic [7:0] rdata;

	// The input register is free when empty or when its item moves on now.
	assign keys.ready = !vld_s1 || free;
	assign commit     = vld_s1 && free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (keys.ready) begin
			vld_s1 <= keys.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (keys.ready && keys.valid) begin
			op_s1  <= keys.opcode;
			key_s1 <= keys.key_byte;
			idx_s1 <= keys.read_index;
		end
	end

	// Editor state advances, and the store is written or read, on commit.
	tle_editor u_editor (
		.clk    (clk),
		.arst_n (arst_n),
		.commit (commit),
		.op     (op_s1),
		.key    (key_s1),
		.idx    (idx_s1),
		.plan   (plan),
		.wr     (wr),
		.rd     (rd)
	);

	// The read data register only changes when a read item is committed, so
	// it holds steady for as long as that item's result waits.
	tle_ram #(
		.WIDTH (8),
		.DEPTH (LINE_CAPACITY)
	) u_store (
		.clk   (clk),
		.we    (wr.we),
		.waddr (wr.addr),
		.wdata (wr.data),
		.re    (rd.re),
		.raddr (rd.addr),
		.rdata (rdata)
	);

	tle_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (commit),
		.plan   (plan),
		.rdata  (rdata),
		.free   (free),
		.res    (results)
	);

	`TLE_ASSERT_NEXT(a_s1_held, vld_s1 && !commit, vld_s1 && $stable(key_s1) && $stable(op_s1),
		"waiting input item lost or changed")

endmodule

>>> tb/sv/tb_terminal_line_editor_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line editor core testbench
// Feeds key and read items through the keys channel under random idling on
// both sides. A behavioural line editor works out the echo bytes, line events
// and read data that each accepted item must cause. Every result transfer is
// checked in order against those expectations.
// ----------------------------------------------------------------------------
module tb_terminal_line_editor_core;
	import tle_pkg::*;

	localparam int TARGET_ITEMS  = 420;
	localparam int CALM_TAIL     = 40;   // items at the end sent with no idling
	localparam int HOLD_CYCLES   = 200;  // long receiver hold-off
	localparam int LONG_LINE     = LINE_CAPACITY + 2;
	localparam int SETTLE_CYCLES = 20;
	localparam int PRINT_LIMIT   = 100;

	typedef struct packed {
		logic       opcode;
		logic [7:0] key_byte;
		logic [7:0] read_index;
	} key_item_t;

	typedef struct {
		key_item_t word;
		bit        drain;  // wait for every awaited result before offering
		bit        hold;   // ask the receiver for a long hold-off
	} queued_key_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] value;
		logic       last;
	} line_event_t;

	logic clk = 1'b0;
	logic arst_n;

	tle_in_if  keys();
	tle_out_if results();

	terminal_line_editor_core dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.keys    (keys),
		.results (results)
	);

	always #4 clk = ~clk;

	// ------------------------------------------------------------------------
	// Behavioural line editor: its own copy of the store, the fill count and
	// the escape phase, plus a record of which store entries hold a value.
	// ------------------------------------------------------------------------
	logic [7:0]  shadow_line [LINE_CAPACITY];
	bit          shadow_written [LINE_CAPACITY];
	int unsigned shadow_fill = 0;
	esc_t        shadow_esc = ESC_IDLE;

	line_event_t burst[$];
	line_event_t awaited_output[$];

	int n_keys = 0, n_reads = 0, n_lines = 0, n_aborts = 0, n_bells = 0;
	int widest_burst = 0;

	task automatic emit(input kind_t k, input logic [7:0] v);
		burst.push_back('{kind: k, value: v, last: 1'b0});
	endtask

	task automatic emit_erase();
		emit(KIND_ECHO, CH_BS);
		emit(KIND_ECHO, CH_SP);
		emit(KIND_ECHO, CH_BS);
	endtask

	task automatic edit_line(input key_item_t it);
		logic [7:0] c;
		bit         bracket_taken;
		burst = {};
		bracket_taken = 1'b0;
		if (it.opcode) begin
			n_reads++;
			emit(KIND_READ, shadow_line[it.read_index]);
		end else begin
			n_keys++;
			c = it.key_byte;
			// Bytes below space, and bytes with the top bit set (negative as a
			// signed char), echo two erase groups before anything else.
			if (c < CH_SP || c[7]) begin
				emit_erase();
				emit_erase();
			end
			case (shadow_esc)
				ESC_SEEN: begin
					// Anything but a bracket leaves the escape pending, unless it ends or aborts the line.
					if (c == CH_LBRACK) begin
						emit_erase();
						shadow_esc = ESC_BRACKET;
						bracket_taken = 1'b1;
					end
				end
				ESC_BRACKET: begin
					emit_erase();
					if (c == CH_UP || c == CH_DOWN || c == CH_RIGHT)
						c = CH_DLE;
					else if (c == CH_LEFT)
						c = CH_DC1;
					shadow_esc = ESC_IDLE;
				end
				default: begin
				end
			endcase
			if (!bracket_taken) begin
				case (c)
					CH_ESC: shadow_esc = ESC_SEEN;
					CH_NUL, CH_NAK, CH_DLE, CH_DC1: begin
					end
					CH_ETX: begin
						shadow_line[0] = 8'h00;
						shadow_written[0] = 1'b1;
						emit(KIND_ABORT, 8'h00);
						shadow_fill = 0;
						shadow_esc = ESC_IDLE;
						n_aborts++;
					end
					CH_CR, CH_LF: begin
						if (shadow_fill < LINE_CAPACITY) begin
							shadow_line[shadow_fill] = 8'h00;
							shadow_written[shadow_fill] = 1'b1;
						end
						emit(KIND_ECHO, CH_CR);
						emit(KIND_ECHO, CH_LF);
						emit(KIND_DONE, 8'(shadow_fill));
						shadow_fill = 0;
						shadow_esc = ESC_IDLE;
						n_lines++;
					end
					CH_BS, CH_DEL: begin
						if (shadow_fill > 0)
							shadow_fill--;
						emit_erase();
					end
					default: begin
						if (shadow_fill < LINE_CAPACITY - 2) begin
							shadow_line[shadow_fill] = c;
							shadow_written[shadow_fill] = 1'b1;
							shadow_fill++;
						end else begin
							emit(KIND_ECHO, CH_BEL);
							n_bells++;
						end
					end
				endcase
			end
		end
		if (burst.size() > 0)
			burst[burst.size()-1].last = 1'b1;
		if (burst.size() > widest_burst)
			widest_burst = burst.size();
		foreach (burst[i])
			awaited_output.push_back(burst[i]);
	endtask

	// ------------------------------------------------------------------------
	// Stimulus store and the tasks that fill it.
	// ------------------------------------------------------------------------
	queued_key_t typed_keys[$];
	int queued_total = 0;

	task automatic queue_key(input logic [7:0] b);
		typed_keys.push_back('{word: '{opcode: 1'b0, key_byte: b, read_index: 8'($urandom)},
			drain: 1'b0, hold: 1'b0});
		queued_total++;
	endtask

	// Reads of entries that hold no value yet are steered to a lower one that does,
	// or turn into key bytes, when offered, as only then is the store contents known.
	task automatic queue_read(input logic [7:0] idx);
		typed_keys.push_back('{word: '{opcode: 1'b1, key_byte: 8'($urandom), read_index: idx},
			drain: 1'b0, hold: 1'b0});
		queued_total++;
	endtask

	function automatic logic [7:0] printable();
		return 8'($urandom_range(CH_SP, CH_DEL - 1));
	endfunction

	// A line of typed text with the odd edit, arrow key, read or stray byte in it,
	// closed by enter, line feed or ^C.
	task automatic queue_line();
		int len;
		int pick;
		len = $urandom_range(0, 12);
		if ($urandom_range(0, 19) == 0 && typed_keys.size() > 0)
			typed_keys[typed_keys.size()-1].drain = 1'b1;
		for (int k = 0; k < len; k++) begin
			pick = $urandom_range(0, 19);
			if (pick < 12)
				queue_key(printable());
			else if (pick < 14)
				queue_key($urandom_range(0, 1) ? CH_BS : CH_DEL);
			else if (pick == 14) begin
				queue_key(CH_ESC);
				queue_key(CH_LBRACK);
				case ($urandom_range(0, 4))
					0: queue_key(CH_UP);
					1: queue_key(CH_DOWN);
					2: queue_key(CH_RIGHT);
					3: queue_key(CH_LEFT);
					default: queue_key(8'($urandom));
				endcase
			end else if (pick == 15) begin
				queue_key(CH_ESC);
				queue_key(8'($urandom));
			end else if (pick == 16)
				queue_read(8'($urandom_range(0, LINE_CAPACITY - 2)));
			else if (pick == 17)
				queue_key(8'($urandom_range(0, CH_SP - 1)));
			else
				queue_key(8'($urandom));
		end
		pick = $urandom_range(0, 9);
		if (pick == 0)
			queue_key(CH_ETX);
		else if (pick < 6)
			queue_key(CH_CR);
		else
			queue_key(CH_LF);
	endtask

	// ------------------------------------------------------------------------
	// Mismatch reporting.
	// ------------------------------------------------------------------------
	int errors = 0;

	task automatic flag_mismatch(input string what);
		if (errors < PRINT_LIMIT)
			$display("%0t ns: mismatch: %s", $time, what);
		errors++;
	endtask

	// ------------------------------------------------------------------------
	// Key driver. Inputs change on the falling edge. An item stays on offer
	// until a transfer takes it; the monitor tells the driver so through
	// key_taken. Bursts of idle cycles come and go with a random mood.
	// ------------------------------------------------------------------------
	bit key_taken = 1'b0;
	bit calm = 1'b0;
	int accepted_total = 0;
	int gap_left = 0;
	int send_mood_left = 0;
	bit send_quiet = 1'b0;
	int hold_asks = 0;

	always @(negedge clk) begin : key_driver
		queued_key_t nxt;
		int idx;
		if (arst_n) begin
			if (send_mood_left == 0) begin
				send_quiet = ($urandom_range(0, 2) == 0);
				send_mood_left = $urandom_range(20, 80);
			end else begin
				send_mood_left--;
			end
			if (keys.valid && !key_taken) begin
				// Still on offer: the block has not taken it yet.
			end else if (gap_left > 0) begin
				keys.valid <= 1'b0;
				gap_left--;
			end else if (typed_keys.size() == 0 ||
				(typed_keys[0].drain && awaited_output.size() != 0)) begin
				keys.valid <= 1'b0;
			end else begin
				nxt = typed_keys.pop_front();
				if (nxt.word.opcode && !shadow_written[nxt.word.read_index]) begin
					idx = nxt.word.read_index;
					while (idx > 0 && !shadow_written[idx])
						idx--;
					if (shadow_written[idx])
						nxt.word.read_index = 8'(idx);
					else
						nxt.word.opcode = 1'b0;
				end
				if (nxt.hold)
					hold_asks <= hold_asks + 1;
				keys.valid      <= 1'b1;
				keys.opcode     <= nxt.word.opcode;
				keys.key_byte   <= nxt.word.key_byte;
				keys.read_index <= nxt.word.read_index;
				if (!calm && !send_quiet && $urandom_range(0, 5) == 0)
					gap_left = $urandom_range(1, 19);
			end
		end
	end

	// ------------------------------------------------------------------------
	// Result receiver. Stalls in random bursts, and on request holds off for
	// a long stretch so that the block backs up and drops keys.ready.
	// ------------------------------------------------------------------------
	int hold_served = 0;
	int hold_left = 0;
	int stall_left = 0;
	int recv_mood_left = 0;
	bit recv_quiet = 1'b0;

	always @(negedge clk) begin : result_receiver
		if (arst_n) begin
			if (hold_asks != hold_served) begin
				hold_served++;
				hold_left = HOLD_CYCLES;
			end
			if (recv_mood_left == 0) begin
				recv_quiet = ($urandom_range(0, 2) == 0);
				recv_mood_left = $urandom_range(20, 80);
			end else begin
				recv_mood_left--;
			end
			if (hold_left > 0) begin
				hold_left--;
				results.ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				results.ready <= 1'b0;
			end else if (!calm && !recv_quiet && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(1, 19) - 1;
				results.ready <= 1'b0;
			end else begin
				results.ready <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Monitor. On the rising edge every key transfer is run through the
	// behavioural editor and every result transfer is checked, field by
	// field, against the oldest awaited result.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin : result_monitor
		line_event_t want;
		if (arst_n) begin
			key_taken <= keys.valid && keys.ready;
			calm <= (accepted_total + CALM_TAIL >= queued_total);
			if (keys.valid && keys.ready) begin
				edit_line('{opcode: keys.opcode, key_byte: keys.key_byte,
					read_index: keys.read_index});
				accepted_total++;
			end
			if (results.valid && results.ready) begin
				if (awaited_output.size() == 0) begin
					flag_mismatch($sformatf("unexpected result kind %0d value %02h last %0b",
						results.kind, results.value, results.last));
				end else begin
					want = awaited_output.pop_front();
					if (results.kind !== want.kind)
						flag_mismatch($sformatf("kind %0d, expected %0d",
							results.kind, want.kind));
					if (results.value !== want.value)
						flag_mismatch($sformatf("value %02h, expected %02h",
							results.value, want.value));
					if (results.last !== want.last)
						flag_mismatch($sformatf("last %0b, expected %0b",
							results.last, want.last));
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus, reset and end of run.
	// ------------------------------------------------------------------------
	initial begin : stimulus
		bit long_done;
		arst_n = 1'b0;
		keys.valid = 1'b0;
		keys.opcode = 1'b0;
		keys.key_byte = 8'h00;
		keys.read_index = 8'h00;
		results.ready = 1'b0;
		foreach (shadow_line[i]) begin
			shadow_line[i] = 8'h00;
			shadow_written[i] = 1'b0;
		end

		// Directed opening: plain bytes, reads, both erase keys, high bytes,
		// ignored controls, the up and left arrows, a stray byte after ESC that keeps
		// the escape pending, a plain byte after ESC [, enter, backspace on an
		// empty line, ^C and an empty line.
		queue_key(8'h61);
		queue_key(CH_SP);
		queue_read(8'd0);
		queue_key(CH_BS);
		queue_key(CH_DEL);
		queue_key(8'h80);
		queue_key(8'hFF);
		queue_key(CH_NUL);
		queue_key(CH_NAK);
		queue_key(CH_ESC);
		queue_key(CH_LBRACK);
		queue_key(CH_UP);
		queue_key(CH_ESC);
		queue_key(8'h78);
		queue_key(CH_LBRACK);
		queue_key(CH_LEFT);
		queue_key(CH_ESC);
		queue_key(CH_LBRACK);
		queue_key(8'h71);
		queue_key(CH_CR);
		queue_key(CH_BS);
		queue_key(8'h7A);
		queue_key(CH_ETX);
		queue_key(CH_LF);
		queue_read(8'd1);

		// Random part: mostly well-formed lines, some noise and read runs,
		// and once a line long enough to fill the store and ring the bell.
		// The long hold-off starts with the first bell, so that the bell
		// results back up and the block stops taking keys.
		long_done = 1'b0;
		while (queued_total < TARGET_ITEMS) begin
			if (!long_done && queued_total >= 120) begin
				long_done = 1'b1;
				queue_key(CH_ETX);
				typed_keys[typed_keys.size()-1].drain = 1'b1;
				for (int k = 0; k < LONG_LINE; k++) begin
					queue_key(printable());
					if (k == LINE_CAPACITY - 2)
						typed_keys[typed_keys.size()-1].hold = 1'b1;
				end
				queue_key(CH_CR);
				queue_read(8'(LINE_CAPACITY - 2));
				queue_read(8'd127);
				queue_read(8'd128);
				queue_read(8'd85);
				queue_read(8'd170);
			end else begin
				case ($urandom_range(0, 9))
					0: for (int k = 0; k < 8; k++)
						queue_key(8'($urandom));
					1: for (int k = 0; k < 4; k++)
						queue_read(8'($urandom_range(0, LINE_CAPACITY - 2)));
					default: queue_line();
				endcase
			end
		end

		repeat (2) @(posedge clk);
		#1 arst_n = 1'b1;

		while (typed_keys.size() != 0 || keys.valid)
			@(posedge clk);
		while (awaited_output.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Sent %0d key bytes and %0d reads: %0d lines ended, %0d aborted, %0d bells.",
			n_keys, n_reads, n_lines, n_aborts, n_bells);
		$display("Largest group of results from one item: %0d; mismatches: %0d.",
			widest_burst, errors);
		if (errors == 0) begin
			$display("[terminal_line_editor_core] OK");
		end else begin
			$display("[terminal_line_editor_core] ERROR");
		end
		$finish;
	end

	// Far beyond the slowest correct run: every item with twelve results,
	// each behind a full receiver stall, plus the sender gaps and hold-off.
	initial begin : watchdog
		#8_000_000;
		$display("Timed out with %0d results still awaited.", awaited_output.size());
		$display("[terminal_line_editor_core] ERROR");
		$finish;
	end

endmodule

>>> sim.f
+incdir+design
design/tle_pkg.sv
design/tle_if.sv
design/tle_ram.sv
design/tle_editor.sv
design/tle_seq.sv
design/terminal_line_editor_core.sv
tb/sv/tb_terminal_line_editor_core.sv
